// ===== hw/rtl/zbps_pkg.sv =====
// ============================================================================
// zbps_pkg
// Shared types and constants for the depth-buffered pixel store.
// ============================================================================
package zbps_pkg;

    localparam int unsigned CFG_AW    = 5;

    localparam logic [1:0] REQ_CLEAR   = 2'd0;
    localparam logic [1:0] REQ_PUT     = 2'd1;
    localparam logic [1:0] REQ_GET     = 2'd2;
    localparam logic [1:0] REQ_READOUT = 2'd3;

    localparam logic [2:0] REG_X_RES    = 3'd0;
    localparam logic [2:0] REG_Y_RES    = 3'd1;
    localparam logic [2:0] REG_BG_RED   = 3'd2;
    localparam logic [2:0] REG_BG_GREEN = 3'd3;
    localparam logic [2:0] REG_BG_BLUE  = 3'd4;

    localparam logic [8:0]  X_RES_RST    = 9'd256;
    localparam logic [8:0]  Y_RES_RST    = 9'd256;
    localparam logic [7:0]  BG_RED_RST   = 8'd128;
    localparam logic [7:0]  BG_GREEN_RST = 8'd112;
    localparam logic [7:0]  BG_BLUE_RST  = 8'd96;

    localparam logic [11:0] COLOR_MAX   = 12'd4095;
    localparam logic [15:0] ALPHA_CLEAR = 16'd1;
    localparam logic [31:0] DEPTH_FAR   = 32'h7FFF_FFFF;

    typedef struct packed {
        logic [11:0]        red;
        logic [11:0]        green;
        logic [11:0]        blue;
        logic signed [15:0] alpha;
        logic signed [31:0] depth;
    } pix_word_t;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_ACCESS = 3'b010,
        S_CLEAR  = 3'b100
    } state_t;

    function automatic logic [11:0] clamp_color(input logic signed [15:0] v);
        logic [11:0] r;
        if (v[15])
            r = 12'd0;
        else if (v[14:12] != 3'd0)
            r = COLOR_MAX;
        else
            r = v[11:0];
        return r;
    endfunction

endpackage

// ===== hw/rtl/zbps_ram.sv =====
// ============================================================================
// zbps_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ============================================================================
module zbps_ram #(
    parameter int unsigned AW = 16,
    parameter int unsigned DW = 84
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [0:(1<<AW)-1];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/zbuffer_pixel_store_core.sv =====
// ============================================================================
// zbuffer_pixel_store_core
// Depth-buffered pixel store: clear, depth-tested put, get and byte readout.
// ============================================================================
// Put, get, readout: accepted at start into the request registers and RAM read;
// S_ACCESS forms the registered result and done. Busy only in S_ACCESS, so a new
// transaction waits for the last, set by the read-modify-write on the single pixel RAM.
// Clear: sweeps all 2**(XW+YW) RAM entries, one entry a cycle, then done.
// Reset: registers to their documented values, pixel RAM undefined until
// the first clear. The result is not back-pressured.
module zbuffer_pixel_store_core
    import zbps_pkg::*;
#(
    parameter int unsigned MAX_WIDTH  = 256,
    parameter int unsigned MAX_HEIGHT = 256
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [CFG_AW-1:0]   paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          req_type,
    input  logic signed [15:0]  pix_x,
    input  logic signed [15:0]  pix_y,
    input  logic signed [15:0]  in_red,
    input  logic signed [15:0]  in_green,
    input  logic signed [15:0]  in_blue,
    input  logic signed [15:0]  in_alpha,
    input  logic signed [31:0]  in_depth,
    output logic                done,
    output logic                status,
    output logic                written,
    output logic [11:0]         out_red,
    output logic [11:0]         out_green,
    output logic [11:0]         out_blue,
    output logic signed [15:0]  out_alpha,
    output logic signed [31:0]  out_depth
);

    localparam int unsigned XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int unsigned YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int unsigned AW = XW + YW;
    localparam int unsigned PW = $bits(pix_word_t);
    localparam logic [15:0] MAXW16 = 16'(MAX_WIDTH);
    localparam logic [15:0] MAXH16 = 16'(MAX_HEIGHT);

    // configuration
    logic [8:0] x_res_reg, y_res_reg;
    logic [7:0] bg_red_reg, bg_green_reg, bg_blue_reg;
    logic       cfg_wr;

    // control and captured request
    state_t             state_reg, state_next;
    logic [1:0]         req_reg;
    logic               hit_reg;
    logic [AW-1:0]      addr_reg;
    logic [AW-1:0]      clr_cnt_reg, clr_cnt_next;
    pix_word_t          put_reg;

    // results
    logic               done_reg, done_next;
    logic               status_reg, status_next;
    logic               written_reg, written_next;
    logic [11:0]        red_reg, red_next;
    logic [11:0]        green_reg, green_next;
    logic [11:0]        blue_reg, blue_next;
    logic signed [15:0] alpha_reg, alpha_next;
    logic signed [31:0] depth_reg, depth_next;

    logic               accept;
    logic               hit;
    logic [AW-1:0]      addr;
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    pix_word_t          ram_wdata;
    pix_word_t          rd_word;
    pix_word_t          clear_word;
    logic [PW-1:0]      rd_bits;
    logic               depth_pass;

    // ------------------------------------------------------------------
    // APB configuration port
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_res_reg    <= X_RES_RST;
            y_res_reg    <= Y_RES_RST;
            bg_red_reg   <= BG_RED_RST;
            bg_green_reg <= BG_GREEN_RST;
            bg_blue_reg  <= BG_BLUE_RST;
        end
        else if (cfg_wr)
        begin
            case (paddr[4:2])
                REG_X_RES:    x_res_reg    <= pwdata[8:0];
                REG_Y_RES:    y_res_reg    <= pwdata[8:0];
                REG_BG_RED:   bg_red_reg   <= pwdata[7:0];
                REG_BG_GREEN: bg_green_reg <= pwdata[7:0];
                REG_BG_BLUE:  bg_blue_reg  <= pwdata[7:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            REG_X_RES:    prdata = {23'd0, x_res_reg};
            REG_Y_RES:    prdata = {23'd0, y_res_reg};
            REG_BG_RED:   prdata = {24'd0, bg_red_reg};
            REG_BG_GREEN: prdata = {24'd0, bg_green_reg};
            REG_BG_BLUE:  prdata = {24'd0, bg_blue_reg};
            default:      prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // Request decode: clip against min(res, MAX) and form the RAM address
    // ------------------------------------------------------------------
    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;

    assign hit = !pix_x[15] && !pix_y[15]
                 && ({1'b0, pix_x[14:0]} < {7'd0, x_res_reg})
                 && ({1'b0, pix_x[14:0]} < MAXW16)
                 && ({1'b0, pix_y[14:0]} < {7'd0, y_res_reg})
                 && ({1'b0, pix_y[14:0]} < MAXH16);

    assign addr = {pix_y[YW-1:0], pix_x[XW-1:0]};

    assign clear_word.red   = {bg_red_reg, 4'd0};
    assign clear_word.green = {bg_green_reg, 4'd0};
    assign clear_word.blue  = {bg_blue_reg, 4'd0};
    assign clear_word.alpha = ALPHA_CLEAR;
    assign clear_word.depth = DEPTH_FAR;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg       <= req_type;
            hit_reg       <= hit;
            addr_reg      <= addr;
            put_reg.red   <= clamp_color(in_red);
            put_reg.green <= clamp_color(in_green);
            put_reg.blue  <= clamp_color(in_blue);
            put_reg.alpha <= in_alpha;
            put_reg.depth <= in_depth;
        end
    end

    // ------------------------------------------------------------------
    // Pixel RAM
    // ------------------------------------------------------------------
    zbps_ram #(
        .AW (AW),
        .DW (PW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (addr),
        .rdata (rd_bits)
    );

    assign rd_word    = pix_word_t'(rd_bits);
    assign depth_pass = !(rd_word.depth < put_reg.depth);

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        ram_we       = 1'b0;
        ram_waddr    = addr_reg;
        ram_wdata    = put_reg;
        done_next    = 1'b0;
        status_next  = status_reg;
        written_next = written_reg;
        red_next     = red_reg;
        green_next   = green_reg;
        blue_next    = blue_reg;
        alpha_next   = alpha_reg;
        depth_next   = depth_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (req_type == REQ_CLEAR)
                        state_next = S_CLEAR;
                    else
                        state_next = S_ACCESS;
                end
            end
            S_ACCESS:
            begin
                state_next   = S_IDLE;
                done_next    = 1'b1;
                status_next  = 1'b0;
                written_next = 1'b0;
                red_next     = 12'd0;
                green_next   = 12'd0;
                blue_next    = 12'd0;
                alpha_next   = 16'sd0;
                depth_next   = 32'sd0;
                if (req_reg == REQ_PUT)
                begin
                    if (hit_reg && depth_pass)
                    begin
                        ram_we       = 1'b1;
                        written_next = 1'b1;
                    end
                end
                else if (!hit_reg)
                begin
                    status_next = 1'b1;
                end
                else if (req_reg == REQ_GET)
                begin
                    red_next   = rd_word.red;
                    green_next = rd_word.green;
                    blue_next  = rd_word.blue;
                    alpha_next = rd_word.alpha;
                    depth_next = rd_word.depth;
                end
                else
                begin
                    red_next   = {4'd0, rd_word.red[11:4]};
                    green_next = {4'd0, rd_word.green[11:4]};
                    blue_next  = {4'd0, rd_word.blue[11:4]};
                end
            end
            S_CLEAR:
            begin
                ram_we       = 1'b1;
                ram_waddr    = clr_cnt_reg;
                ram_wdata    = clear_word;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == {AW{1'b1}})
                begin
                    state_next   = S_IDLE;
                    done_next    = 1'b1;
                    status_next  = 1'b0;
                    written_next = 1'b0;
                    red_next     = 12'd0;
                    green_next   = 12'd0;
                    blue_next    = 12'd0;
                    alpha_next   = 16'sd0;
                    depth_next   = 32'sd0;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            clr_cnt_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg  <= status_next;
        written_reg <= written_next;
        red_reg     <= red_next;
        green_reg   <= green_next;
        blue_reg    <= blue_next;
        alpha_reg   <= alpha_next;
        depth_reg   <= depth_next;
    end

    assign done      = done_reg;
    assign status    = status_reg;
    assign written   = written_reg;
    assign out_red   = red_reg;
    assign out_green = green_reg;
    assign out_blue  = blue_reg;
    assign out_alpha = alpha_reg;
    assign out_depth = depth_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_done_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg) != S_IDLE)
        else $error("result strobe without a transaction in flight");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg != S_IDLE)
        else $error("accepted transaction did not start");

    a_write_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> state_reg != S_IDLE)
        else $error("RAM written while idle");

    a_written_not_status: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !(written_reg && status_reg))
        else $error("written and status both set");

    a_clear_count_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> clr_cnt_reg == '0)
        else $error("clear counter not back at zero");

endmodule

// ===== tb/sv/tb_zbuffer_pixel_store_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_zbuffer_pixel_store_core
// Self-checking bench for the depth-buffered pixel store. Requests are driven
// through the start/busy port in random bursts, each accepted transaction is
// run through a local pixel-store predictor and every done strobe is checked
// field by field against the oldest predicted answer. The register port is
// reprogrammed between phases, covering unit, zero and oversized resolutions.
// ----------------------------------------------------------------------------
module tb_zbuffer_pixel_store_core;
    import zbps_pkg::*;

    localparam int MAX_W  = 256;
    localparam int MAX_H  = 256;
    localparam int PIXELS = MAX_W * MAX_H;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] r;
        logic signed [15:0] g;
        logic signed [15:0] b;
        logic signed [15:0] a;
        logic signed [31:0] z;
    } pix_req_t;

    typedef struct packed {
        logic               status;
        logic               written;
        logic [11:0]        red;
        logic [11:0]        green;
        logic [11:0]        blue;
        logic signed [15:0] alpha;
        logic signed [31:0] depth;
    } pix_res_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [CFG_AW-1:0]   paddr = '0;
    logic [31:0]         pwdata = '0;
    logic [31:0]         prdata;
    logic                pready;
    logic                start = 1'b0;
    logic                busy;
    logic                done;
    logic                status;
    logic                written;
    logic [11:0]         out_red;
    logic [11:0]         out_green;
    logic [11:0]         out_blue;
    logic signed [15:0]  out_alpha;
    logic signed [31:0]  out_depth;

    pix_req_t drv_req = '0;

    // local copy of the registers and the pixel store
    logic [8:0]          cfg_x_res = X_RES_RST;
    logic [8:0]          cfg_y_res = Y_RES_RST;
    logic [7:0]          cfg_bg_red = BG_RED_RST;
    logic [7:0]          cfg_bg_green = BG_GREEN_RST;
    logic [7:0]          cfg_bg_blue = BG_BLUE_RST;
    logic [35:0]         colour_mem [0:PIXELS-1];
    logic signed [15:0]  alpha_mem [0:PIXELS-1];
    logic signed [31:0]  depth_mem [0:PIXELS-1];

    pix_req_t            pixel_queue [$];
    pix_res_t            pixel_answers [$];
    int unsigned         mismatches = 0;
    logic                took = 1'b0;
    int unsigned         burst_left = 0;
    int unsigned         gap_left = 0;

    zbuffer_pixel_store_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .start     (start),
        .busy      (busy),
        .req_type  (drv_req.kind),
        .pix_x     (drv_req.x),
        .pix_y     (drv_req.y),
        .in_red    (drv_req.r),
        .in_green  (drv_req.g),
        .in_blue   (drv_req.b),
        .in_alpha  (drv_req.a),
        .in_depth  (drv_req.z),
        .done      (done),
        .status    (status),
        .written   (written),
        .out_red   (out_red),
        .out_green (out_green),
        .out_blue  (out_blue),
        .out_alpha (out_alpha),
        .out_depth (out_depth)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int active_len(input logic [8:0] res, input int lim);
        return (int'(res) < lim) ? int'(res) : lim;
    endfunction

    function automatic logic [11:0] clip12(input logic signed [15:0] v);
        int vi;
        vi = v;
        if (vi < 0)
            return 12'd0;
        if (vi > 4095)
            return 12'd4095;
        return vi[11:0];
    endfunction

    task automatic zbuf_compute(input pix_req_t q, output pix_res_t ans);
        int          w;
        int          h;
        int          xi;
        int          yi;
        logic        hit;
        logic [15:0] idx;
        logic [35:0] c;
        ans = '0;
        w   = active_len(cfg_x_res, MAX_W);
        h   = active_len(cfg_y_res, MAX_H);
        xi  = q.x;
        yi  = q.y;
        hit = (xi >= 0) && (xi < w) && (yi >= 0) && (yi < h);
        idx = 16'(yi * MAX_W + xi);
        case (q.kind)
            REQ_CLEAR:
            begin
                for (int k = 0; k < PIXELS; k++)
                begin
                    colour_mem[k] = {cfg_bg_red, 4'd0, cfg_bg_green, 4'd0, cfg_bg_blue, 4'd0};
                    alpha_mem[k]  = ALPHA_CLEAR;
                    depth_mem[k]  = DEPTH_FAR;
                end
            end
            REQ_PUT:
            begin
                if (hit && !(depth_mem[idx] < q.z))
                begin
                    colour_mem[idx] = {clip12(q.r), clip12(q.g), clip12(q.b)};
                    alpha_mem[idx]  = q.a;
                    depth_mem[idx]  = q.z;
                    ans.written     = 1'b1;
                end
            end
            default:
            begin
                if (!hit)
                    ans.status = 1'b1;
                else
                begin
                    c = colour_mem[idx];
                    if (q.kind == REQ_GET)
                    begin
                        ans.red   = c[35:24];
                        ans.green = c[23:12];
                        ans.blue  = c[11:0];
                        ans.alpha = alpha_mem[idx];
                        ans.depth = depth_mem[idx];
                    end
                    else
                    begin
                        ans.red   = c[35:24] >> 4;
                        ans.green = c[23:12] >> 4;
                        ans.blue  = c[11:0] >> 4;
                    end
                end
            end
        endcase
    endtask

    function automatic pix_req_t pixel(input logic [1:0] kind, input int x, input int y,
                                       input int r, input int g, input int b, input int a,
                                       input logic [31:0] z);
        pix_req_t q;
        q.kind = kind;
        q.x    = x[15:0];
        q.y    = y[15:0];
        q.r    = r[15:0];
        q.g    = g[15:0];
        q.b    = b[15:0];
        q.a    = a[15:0];
        q.z    = z;
        return q;
    endfunction

    // mostly a small hot window and the far edge, so reads land on written pixels
    function automatic logic [15:0] rand_coord(input int lim);
        int sel;
        int v;
        sel = $urandom_range(0, 9);
        if (lim == 0 || sel >= 8)
            v = $urandom_range(0, 65535);
        else if (sel == 7)
            v = ($urandom_range(0, 1) != 0) ? lim : -1;
        else if (sel < 4)
            v = $urandom_range(0, (lim < 8) ? lim - 1 : 7);
        else if (sel < 6)
            v = lim - 1 - int'($urandom_range(0, (lim < 4) ? lim - 1 : 3));
        else
            v = $urandom_range(0, lim - 1);
        return v[15:0];
    endfunction

    function automatic logic [15:0] rand_colour();
        case ($urandom_range(0, 7))
            0:       return 16'h8000;
            1:       return 16'hFFFF;
            2:       return 16'h0000;
            3:       return 16'd4095;
            4:       return 16'd4096;
            5:       return 16'h7FFF;
            6:       return 16'($urandom_range(0, 4095));
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [31:0] rand_depth();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 3)
            return $urandom();
        if (sel == 3)
            return 32'h8000_0000;
        if (sel == 4)
            return DEPTH_FAR;
        return 32'($urandom_range(0, 2000)) - 32'd1000;
    endfunction

    function automatic pix_req_t rand_pixel();
        pix_req_t q;
        int       sel;
        sel    = $urandom_range(0, 99);
        q.kind = (sel < 45) ? REQ_PUT : (sel < 70) ? REQ_GET : REQ_READOUT;
        q.x    = rand_coord(active_len(cfg_x_res, MAX_W));
        q.y    = rand_coord(active_len(cfg_y_res, MAX_H));
        q.r    = rand_colour();
        q.g    = rand_colour();
        q.b    = rand_colour();
        q.a    = 16'($urandom_range(0, 65535));
        q.z    = rand_depth();
        return q;
    endfunction

    task automatic run_random(input int n);
        repeat (n) pixel_queue.push_back(rand_pixel());
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (pixel_queue.size() != 0 || start || pixel_answers.size() != 0);
        repeat (4) @(negedge clk);
        @(posedge clk);
    endtask

    task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = val;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        case (idx)
            REG_X_RES:    cfg_x_res    = val[8:0];
            REG_Y_RES:    cfg_y_res    = val[8:0];
            REG_BG_RED:   cfg_bg_red   = val[7:0];
            REG_BG_GREEN: cfg_bg_green = val[7:0];
            default:      cfg_bg_blue  = val[7:0];
        endcase
    endtask

    task automatic set_config(input int xr, input int yr, input int br, input int bgr,
                              input int bb);
        reg_write(REG_X_RES, xr);
        reg_write(REG_Y_RES, yr);
        reg_write(REG_BG_RED, br);
        reg_write(REG_BG_GREEN, bgr);
        reg_write(REG_BG_BLUE, bb);
        @(posedge clk);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    // driver: new transaction at the falling edge once the last one was taken
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (start && !took)
            begin
                // held until accepted
            end
            else if (gap_left > 0)
            begin
                start    <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (pixel_queue.size() > 0)
            begin
                drv_req <= pixel_queue.pop_front();
                start   <= 1'b1;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 24);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                start <= 1'b0;
        end
    end

    // monitor: check results, predict accepted transactions
    always @(posedge clk)
    begin
        pix_res_t want;
        pix_res_t fresh;
        took <= rst_n && start && !busy;
        if (rst_n && done)
        begin
            if (pixel_answers.size() == 0)
            begin
                mismatches++;
                $display("%0t ns: result with no transaction outstanding", $time);
            end
            else
            begin
                want = pixel_answers.pop_front();
                check_field("status", want.status, status);
                check_field("written", want.written, written);
                check_field("out_red", want.red, out_red);
                check_field("out_green", want.green, out_green);
                check_field("out_blue", want.blue, out_blue);
                check_field("out_alpha", want.alpha, out_alpha);
                check_field("out_depth", want.depth, out_depth);
            end
        end
        if (rst_n && start && !busy)
        begin
            zbuf_compute(drv_req, fresh);
            pixel_answers.push_back(fresh);
        end
    end

    initial
    begin
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // reset configuration
        pixel_queue.push_back(pixel(REQ_CLEAR, 0, 0, 0, 0, 0, 0, 0));
        pixel_queue.push_back(pixel(REQ_GET, 0, 0, 0, 0, 0, 0, 0));
        pixel_queue.push_back(pixel(REQ_READOUT, 255, 255, 0, 0, 0, 0, 0));
        pixel_queue.push_back(pixel(REQ_GET, 256, 0, 0, 0, 0, 0, 0));
        pixel_queue.push_back(pixel(REQ_READOUT, -1, 0, 0, 0, 0, 0, 0));
        pixel_queue.push_back(pixel(REQ_GET, 0, 256, 0, 0, 0, 0, 0));
        pixel_queue.push_back(pixel(REQ_GET, -32768, 32767, 0, 0, 0, 0, 0));
        pixel_queue.push_back(pixel(REQ_PUT, 0, 0, -32768, 4096, 32767, -32768, 0));
        pixel_queue.push_back(pixel(REQ_GET, 0, 0, 0, 0, 0, 0, 0));
        pixel_queue.push_back(pixel(REQ_READOUT, 0, 0, 0, 0, 0, 0, 0));
        pixel_queue.push_back(pixel(REQ_PUT, 0, 0, 4095, 0, -1, 32767, 0));
        pixel_queue.push_back(pixel(REQ_PUT, 0, 0, 1, 2, 3, 4, 1));
        pixel_queue.push_back(pixel(REQ_GET, 0, 0, 0, 0, 0, 0, 0));
        pixel_queue.push_back(pixel(REQ_PUT, 255, 255, 100, 200, 300, -1, 32'h8000_0000));
        pixel_queue.push_back(pixel(REQ_PUT, 255, 255, 32767, 4095, 17, 5, 32'h8000_0000));
        pixel_queue.push_back(pixel(REQ_PUT, 254, 255, 16, 4080, 255, 0, DEPTH_FAR));
        pixel_queue.push_back(pixel(REQ_PUT, 256, 5, 1, 1, 1, 1, 0));
        pixel_queue.push_back(pixel(REQ_PUT, -1, 5, 1, 1, 1, 1, 0));
        pixel_queue.push_back(pixel(REQ_PUT, 5, -32768, 1, 1, 1, 1, 0));
        pixel_queue.push_back(pixel(REQ_READOUT, 255, 255, 0, 0, 0, 0, 0));
        pixel_queue.push_back(pixel(REQ_GET, 254, 255, 0, 0, 0, 0, 0));
        pixel_queue.push_back(pixel(REQ_GET, -1, -1, -1, -1, -1, -1, 32'hFFFF_FFFF));
        run_random(150);
        wait_idle();

        // single column, black background
        set_config(1, 256, 0, 0, 0);
        pixel_queue.push_back(pixel(REQ_CLEAR, 0, 0, 0, 0, 0, 0, 0));
        run_random(120);
        wait_idle();

        // width beyond the store, single row, white background
        set_config(511, 1, 255, 255, 255);
        pixel_queue.push_back(pixel(REQ_CLEAR, 0, 0, 0, 0, 0, 0, 0));
        pixel_queue.push_back(pixel(REQ_GET, 255, 0, 0, 0, 0, 0, 0));
        pixel_queue.push_back(pixel(REQ_GET, 256, 0, 0, 0, 0, 0, 0));
        pixel_queue.push_back(pixel(REQ_READOUT, 0, 1, 0, 0, 0, 0, 0));
        pixel_queue.push_back(pixel(REQ_PUT, 255, 0, 7, 8, 9, 10, 0));
        run_random(120);
        wait_idle();

        // zero resolution: every coordinate out of range
        set_config(0, 0, $urandom_range(0, 255), $urandom_range(0, 255),
                   $urandom_range(0, 255));
        pixel_queue.push_back(pixel(REQ_PUT, 0, 0, 1, 1, 1, 1, 32'h8000_0000));
        pixel_queue.push_back(pixel(REQ_GET, 0, 0, 0, 0, 0, 0, 0));
        pixel_queue.push_back(pixel(REQ_READOUT, 0, 0, 0, 0, 0, 0, 0));
        run_random(40);
        wait_idle();

        set_config(37, 200, $urandom_range(0, 255), $urandom_range(0, 255),
                   $urandom_range(0, 255));
        pixel_queue.push_back(pixel(REQ_CLEAR, 0, 0, 0, 0, 0, 0, 0));
        run_random(250);
        wait_idle();

        set_config(256, 256, $urandom_range(0, 255), $urandom_range(0, 255),
                   $urandom_range(0, 255));
        run_random(100);
        wait_idle();
        pixel_queue.push_back(pixel(REQ_CLEAR, 0, 0, 0, 0, 0, 0, 0));
        run_random(100);
        wait_idle();

        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #25_000_000;
        $display("%0t ns: timeout", $time);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/zbps_pkg.sv
hw/rtl/zbps_ram.sv
hw/rtl/zbuffer_pixel_store_core.sv
tb/sv/tb_zbuffer_pixel_store_core.sv
